@@ sv/hts_pkg.sv @@
// shared types, constants and lookup functions for the html tag strip and entity decode block
// no dependencies

package hts_pkg;

   localparam int ENT_DEPTH = 5;
   localparam int CNT_W     = 3;

   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_LB   = 8'h62;
   localparam logic [7:0] CH_LR   = 8'h72;

   localparam logic [1:0] ENT_LT_IDX   = 2'd0;
   localparam logic [1:0] ENT_GT_IDX   = 2'd1;
   localparam logic [1:0] ENT_QUOT_IDX = 2'd2;
   localparam logic [1:0] ENT_AMP_IDX  = 2'd3;

   localparam logic [1:0] POS_FIRST = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_DONE  = 2'd2;

   typedef struct packed {
      logic [ENT_DEPTH-1:0][7:0] letters;
      logic [CNT_W-1:0]          lcnt;
      logic                      xvld;
      logic [7:0]                xbyte;
      logic                      bare;
      logic                      eom;
      logic                      open_tag;
   } burst_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] ent_len(input logic [1:0] c);
      logic [CNT_W-1:0] r;
      case (c)
         ENT_LT_IDX:   r = 3'd4;
         ENT_GT_IDX:   r = 3'd4;
         ENT_QUOT_IDX: r = 3'd6;
         ENT_AMP_IDX:  r = 3'd5;
         default:      r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ent_out(input logic [1:0] c);
      logic [7:0] r;
      case (c)
         ENT_LT_IDX:   r = CH_LT;
         ENT_GT_IDX:   r = CH_GT;
         ENT_QUOT_IDX: r = CH_QUOT;
         ENT_AMP_IDX:  r = CH_AMP;
         default:      r = 8'h00;
      endcase
      return r;
   endfunction

   // pattern character at position p, '&' at position 0
   function automatic logic [7:0] ent_char(input logic [1:0] c, input logic [CNT_W-1:0] p);
      logic [7:0] r;
      r = 8'h00;
      case (c)
         ENT_LT_IDX: begin
            case (p)
               3'd0:    r = CH_AMP;
               3'd1:    r = 8'h6C;
               3'd2:    r = 8'h74;
               3'd3:    r = CH_SEMI;
               default: r = 8'h00;
            endcase
         end
         ENT_GT_IDX: begin
            case (p)
               3'd0:    r = CH_AMP;
               3'd1:    r = 8'h67;
               3'd2:    r = 8'h74;
               3'd3:    r = CH_SEMI;
               default: r = 8'h00;
            endcase
         end
         ENT_QUOT_IDX: begin
            case (p)
               3'd0:    r = CH_AMP;
               3'd1:    r = 8'h71;
               3'd2:    r = 8'h75;
               3'd3:    r = 8'h6F;
               3'd4:    r = 8'h74;
               3'd5:    r = CH_SEMI;
               default: r = 8'h00;
            endcase
         end
         ENT_AMP_IDX: begin
            case (p)
               3'd0:    r = CH_AMP;
               3'd1:    r = 8'h61;
               3'd2:    r = 8'h6D;
               3'd3:    r = 8'h70;
               3'd4:    r = CH_SEMI;
               default: r = 8'h00;
            endcase
         end
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

@@ sv/hts_ifs.sv @@
// valid/ready channel interfaces for the request and response sides
// depends on nothing

interface hts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_message;

   modport source (output valid, output in_byte, output end_of_message, input ready);
   modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface hts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       message_end;
   logic       open_tag_at_end;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output message_end, output open_tag_at_end, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input message_end, input open_tag_at_end, output ready);
endinterface

@@ sv/hts_core.sv @@
// tag and entity state plus the single pass decode of one byte into a result burst
// depends on hts_pkg

module hts_core import hts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic       end_of_message,
   output burst_type  burst,
   output logic       has_result
);

   logic                      tag_ff, tag_in;
   logic [1:0]                pos_ff, pos_in;
   logic                      brk_ff, brk_in;
   logic [CNT_W-1:0]          len_ff, len_in;
   logic [3:0]                cand_ff, cand_in;
   logic [ENT_DEPTH-1:0][7:0] ent_ff, ent_in;

   logic [7:0] low;
   logic [3:0] keep;
   logic [3:0] done;
   logic       hit;
   logic       plain;
   logic [7:0] dec;

   always_comb begin
      low = to_lower(in_byte);
      dec = 8'h00;
      for (int c = 0; c < 4; c++) begin
         keep[c] = cand_ff[c] && (len_ff < ent_len(2'(c))) &&
                   (low == ent_char(2'(c), len_ff));
         done[c] = (len_ff + 3'd1) == ent_len(2'(c));
      end
      for (int c = 3; c >= 0; c--) begin
         if (keep[c] && done[c]) begin
            dec = ent_out(2'(c));
         end
      end
      hit = |(keep & done);
   end

   always_comb begin
      tag_in  = tag_ff;
      pos_in  = pos_ff;
      brk_in  = brk_ff;
      len_in  = len_ff;
      cand_in = cand_ff;
      ent_in  = ent_ff;
      plain   = 1'b0;

      burst          = '0;
      burst.letters  = ent_ff;
      burst.xbyte    = in_byte;
      burst.eom      = end_of_message;

      if (len_ff != '0) begin
         if (hit) begin
            burst.xvld  = 1'b1;
            burst.xbyte = dec;
            len_in      = '0;
            cand_in     = '0;
         end else if (keep == '0 || len_ff >= CNT_W'(ENT_DEPTH)) begin
            burst.lcnt = len_ff;
            len_in     = '0;
            cand_in    = '0;
            plain      = 1'b1;
         end else begin
            ent_in[len_ff] = in_byte;
            len_in         = len_ff + 3'd1;
            cand_in        = keep;
            // pending entity at end of message goes out unchanged
            if (end_of_message) begin
               burst.lcnt = len_ff;
               burst.xvld = 1'b1;
            end
         end
      end else begin
         plain = 1'b1;
      end

      if (plain) begin
         if (tag_ff) begin
            if (in_byte == CH_GT) begin
               if (brk_ff) begin
                  burst.xvld  = 1'b1;
                  burst.xbyte = CH_LF;
               end
               tag_in = 1'b0;
               pos_in = POS_FIRST;
               brk_in = 1'b0;
            end else if (pos_ff == POS_FIRST) begin
               pos_in = (low == CH_LB) ? POS_SECOND : POS_DONE;
            end else if (pos_ff == POS_SECOND) begin
               brk_in = (low == CH_LR);
               pos_in = POS_DONE;
            end
         end else if (in_byte == CH_LT) begin
            tag_in = 1'b1;
            pos_in = POS_FIRST;
            brk_in = 1'b0;
         end else if (in_byte == CH_AMP) begin
            ent_in[0] = in_byte;
            len_in    = 3'd1;
            cand_in   = 4'hF;
            if (end_of_message) begin
               burst.xvld = 1'b1;
            end
         end else begin
            burst.xvld = 1'b1;
         end
      end

      if (end_of_message) begin
         burst.open_tag = tag_in;
         tag_in  = 1'b0;
         pos_in  = POS_FIRST;
         brk_in  = 1'b0;
         len_in  = '0;
         cand_in = '0;
         if (burst.lcnt == '0 && !burst.xvld) begin
            burst.xvld  = 1'b1;
            burst.xbyte = 8'h00;
            burst.bare  = 1'b1;
         end
      end

      has_result = (burst.lcnt != '0) || burst.xvld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= 1'b0;
         pos_ff  <= POS_FIRST;
         brk_ff  <= 1'b0;
         len_ff  <= '0;
         cand_ff <= '0;
      end else if (step) begin
         tag_ff  <= tag_in;
         pos_ff  <= pos_in;
         brk_ff  <= brk_in;
         len_ff  <= len_in;
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ent_ff <= ent_in;
      end
   end

endmodule

@@ sv/hts_out.sv @@
// result register holding one burst and sending its bytes one item per cycle while rsp_bus is ready
// depends on hts_pkg and hts_rsp_if

module hts_out import hts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      out_free,
   hts_rsp_if.source rsp_bus
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] k_ff, k_in;
   burst_type        bst_ff;
   logic [CNT_W-1:0] n;
   logic             last;
   logic             from_letters;

   assign n            = bst_ff.lcnt + {{(CNT_W-1){1'b0}}, bst_ff.xvld};
   assign last         = k_ff == (n - 3'd1);
   assign from_letters = k_ff < bst_ff.lcnt;
   assign out_free     = !busy_ff || (rsp_bus.ready && last);

   assign rsp_bus.valid           = busy_ff;
   assign rsp_bus.out_byte        = from_letters ? bst_ff.letters[k_ff] : bst_ff.xbyte;
   assign rsp_bus.byte_valid      = !(last && bst_ff.bare);
   assign rsp_bus.run_last        = last;
   assign rsp_bus.message_end     = last && bst_ff.eom;
   assign rsp_bus.open_tag_at_end = last && bst_ff.eom && bst_ff.open_tag;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (load) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (busy_ff && rsp_bus.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bst_ff <= burst;
      end
   end

   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff < n))
      else $error("run index past end of burst");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("burst loaded over a pending result");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.run_last) |=> rsp_bus.valid)
      else $error("run dropped before its last item");

   a_bare_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.byte_valid) |-> (rsp_bus.run_last && rsp_bus.message_end))
      else $error("bare end marker not a lone final item");

endmodule

@@ sv/html_tag_strip_entity_decode.sv @@
// html tag strip and entity decode, top level
// depends on hts_pkg, hts_req_if, hts_rsp_if, hts_core and hts_out
//
// req_bus carries one text byte per item plus an end-of-message flag; rsp_bus
// carries decoded bytes, each with run_last on the final item caused by one
// request, message_end on the final item of a message and open_tag_at_end
// when that message stopped inside an unclosed tag. A message end that
// produces nothing gives one bare marker item with byte_valid low.
// An accepted request sits in the input register, is decoded combinationally
// into the output register once that register is free and is offered on
// rsp_bus from there. Throughput is one request per cycle while the receiver
// is ready and each request makes at most one item; a request that makes
// several items (up to six, on a failed entity match) holds the output
// register until its last item is taken, which sets the sustained rate.
// A request may be taken while a finished item waits on a stalled receiver;
// further requests wait until the output register frees.
// Synchronous reset clears the tag and entity state and empties both
// registers; no clearing pass is needed.

module html_tag_strip_entity_decode import hts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hts_req_if.sink   req_bus,
   hts_rsp_if.source rsp_bus
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_eom_ff;
   logic       accept;
   logic       advance;
   logic       out_free;
   logic       has_result;
   burst_type  burst;

   assign req_bus.ready = !in_vld_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign advance       = in_vld_ff && out_free;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_bus.in_byte;
         in_eom_ff  <= req_bus.end_of_message;
      end
   end

   hts_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .in_byte        (in_byte_ff),
      .end_of_message (in_eom_ff),
      .burst          (burst),
      .has_result     (has_result)
   );

   hts_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && has_result),
      .burst    (burst),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
